// ===== src/bsq_pkg.sv =====
// Shared types, codes and reset constants for the battery stage qualifier.
// Used by the interfaces, the register block, the classifier, the dwell
// logic and the top level.
package bsq_pkg;

  localparam int ADC_BITS_DEF = 12;
  localparam int RST_CODE_BITS = 12;
  localparam int MS_BITS = 16;
  localparam int STEP_BITS = 10;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_ADDR_BITS = 5;

  localparam logic [MS_BITS-1:0] MS_MAX = {MS_BITS{1'b1}};

  // Reset thresholds, given as 12-bit codes.
  localparam logic [RST_CODE_BITS-1:0] RST_DEAD_BELOW = 12'd2638;
  localparam logic [RST_CODE_BITS-1:0] RST_WEAPON_CUT_BELOW = 12'd2864;
  localparam logic [RST_CODE_BITS-1:0] RST_HALF_BELOW = 12'd3091;
  localparam logic [RST_CODE_BITS-1:0] RST_FULL_BELOW = 12'd3544;
  localparam logic [RST_CODE_BITS-1:0] RST_OVERFULL_FROM = 12'd3714;
  localparam logic [STEP_BITS-1:0] RST_STEP_MS = 10'd10;
  localparam logic [MS_BITS-1:0] RST_DWELL_MS = 16'd1000;

  typedef enum logic [2:0] {
    STAGE_UNDEF = 3'd0,
    STAGE_DEAD = 3'd1,
    STAGE_WEAPON_CUT = 3'd2,
    STAGE_UNDER_HALF = 3'd3,
    STAGE_OVER_HALF = 3'd4,
    STAGE_FULL = 3'd5,
    STAGE_OVERFULL = 3'd6
  } stage_t;

  typedef enum logic [2:0] {
    REG_DEAD_BELOW = 3'd0,
    REG_WEAPON_CUT_BELOW = 3'd1,
    REG_HALF_BELOW = 3'd2,
    REG_FULL_BELOW = 3'd3,
    REG_OVERFULL_FROM = 3'd4,
    REG_STEP_MS = 3'd5,
    REG_DWELL_MS = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [STEP_BITS-1:0] step_ms;
    logic [MS_BITS-1:0] dwell_ms;
  } dwell_cfg_t;

  typedef struct packed {
    logic [2:0] stage;
    logic [2:0] raw_class;
    logic switched;
  } result_t;

  // Rescales a 12-bit reset code to the configured ADC width.
  function automatic logic [31:0] scale_code(input logic [RST_CODE_BITS-1:0] code,
                                             input int bits);
    logic [31:0] wide;
    wide = 32'(code);
    if (bits >= RST_CODE_BITS) begin
      scale_code = wide << (bits - RST_CODE_BITS);
    end else begin
      scale_code = wide >> (RST_CODE_BITS - bits);
    end
  endfunction

endpackage

// ===== src/bsq_if.sv =====
// Valid/ready channel interfaces for the sample words and the result words.
// Depends on bsq_pkg.
interface bsq_in_if #(
  parameter int ADC_BITS = bsq_pkg::ADC_BITS_DEF
);
  logic valid;
  logic ready;
  logic [ADC_BITS-1:0] adc_code;

  modport source (output valid, output adc_code, input ready);
  modport sink (input valid, input adc_code, output ready);
endinterface

interface bsq_out_if;
  logic valid;
  logic ready;
  logic [2:0] stage;
  logic [2:0] raw_class;
  logic switched;

  modport source (output valid, output stage, output raw_class, output switched,
                  input ready);
  modport sink (input valid, input stage, input raw_class, input switched,
                output ready);
endinterface

// ===== src/bsq_cfg_regs.sv =====
// APB-style register block holding the band thresholds and dwell settings.
// Depends on bsq_pkg.
module bsq_cfg_regs #(
  parameter int ADC_BITS = bsq_pkg::ADC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_psel,
  input  logic cfg_penable,
  input  logic cfg_pwrite,
  input  logic [bsq_pkg::CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [bsq_pkg::CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [bsq_pkg::CFG_DATA_BITS-1:0] cfg_prdata,
  output logic cfg_pready,
  output logic [ADC_BITS-1:0] dead_below,
  output logic [ADC_BITS-1:0] weapon_cut_below,
  output logic [ADC_BITS-1:0] half_below,
  output logic [ADC_BITS-1:0] full_below,
  output logic [ADC_BITS-1:0] overfull_from,
  output bsq_pkg::dwell_cfg_t dwell_cfg
);

  localparam logic [ADC_BITS-1:0] RST_DEAD =
    ADC_BITS'(bsq_pkg::scale_code(bsq_pkg::RST_DEAD_BELOW, ADC_BITS));
  localparam logic [ADC_BITS-1:0] RST_WEAPON =
    ADC_BITS'(bsq_pkg::scale_code(bsq_pkg::RST_WEAPON_CUT_BELOW, ADC_BITS));
  localparam logic [ADC_BITS-1:0] RST_HALF =
    ADC_BITS'(bsq_pkg::scale_code(bsq_pkg::RST_HALF_BELOW, ADC_BITS));
  localparam logic [ADC_BITS-1:0] RST_FULL =
    ADC_BITS'(bsq_pkg::scale_code(bsq_pkg::RST_FULL_BELOW, ADC_BITS));
  localparam logic [ADC_BITS-1:0] RST_OVERFULL =
    ADC_BITS'(bsq_pkg::scale_code(bsq_pkg::RST_OVERFULL_FROM, ADC_BITS));

  logic [ADC_BITS-1:0] dead_r, weapon_r, half_r, full_r, overfull_r;
  logic [bsq_pkg::STEP_BITS-1:0] step_r;
  logic [bsq_pkg::MS_BITS-1:0] dwell_r;
  logic wr_en;
  bsq_pkg::reg_idx_t idx;

  assign idx = bsq_pkg::reg_idx_t'(cfg_paddr[bsq_pkg::CFG_ADDR_BITS-1:2]);
  assign wr_en = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_r <= RST_DEAD;
      weapon_r <= RST_WEAPON;
      half_r <= RST_HALF;
      full_r <= RST_FULL;
      overfull_r <= RST_OVERFULL;
      step_r <= bsq_pkg::RST_STEP_MS;
      dwell_r <= bsq_pkg::RST_DWELL_MS;
    end else if (wr_en) begin
      unique case (idx)
        bsq_pkg::REG_DEAD_BELOW: dead_r <= cfg_pwdata[ADC_BITS-1:0];
        bsq_pkg::REG_WEAPON_CUT_BELOW: weapon_r <= cfg_pwdata[ADC_BITS-1:0];
        bsq_pkg::REG_HALF_BELOW: half_r <= cfg_pwdata[ADC_BITS-1:0];
        bsq_pkg::REG_FULL_BELOW: full_r <= cfg_pwdata[ADC_BITS-1:0];
        bsq_pkg::REG_OVERFULL_FROM: overfull_r <= cfg_pwdata[ADC_BITS-1:0];
        bsq_pkg::REG_STEP_MS: step_r <= cfg_pwdata[bsq_pkg::STEP_BITS-1:0];
        bsq_pkg::REG_DWELL_MS: dwell_r <= cfg_pwdata[bsq_pkg::MS_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      bsq_pkg::REG_DEAD_BELOW: cfg_prdata = bsq_pkg::CFG_DATA_BITS'(dead_r);
      bsq_pkg::REG_WEAPON_CUT_BELOW: cfg_prdata = bsq_pkg::CFG_DATA_BITS'(weapon_r);
      bsq_pkg::REG_HALF_BELOW: cfg_prdata = bsq_pkg::CFG_DATA_BITS'(half_r);
      bsq_pkg::REG_FULL_BELOW: cfg_prdata = bsq_pkg::CFG_DATA_BITS'(full_r);
      bsq_pkg::REG_OVERFULL_FROM: cfg_prdata = bsq_pkg::CFG_DATA_BITS'(overfull_r);
      bsq_pkg::REG_STEP_MS: cfg_prdata = bsq_pkg::CFG_DATA_BITS'(step_r);
      bsq_pkg::REG_DWELL_MS: cfg_prdata = bsq_pkg::CFG_DATA_BITS'(dwell_r);
      default: cfg_prdata = '0;
    endcase
  end

  assign dead_below = dead_r;
  assign weapon_cut_below = weapon_r;
  assign half_below = half_r;
  assign full_below = full_r;
  assign overfull_from = overfull_r;
  assign dwell_cfg.step_ms = step_r;
  assign dwell_cfg.dwell_ms = dwell_r;

endmodule

// ===== src/bsq_classify.sv =====
// Band classifier: places one ADC code in one of the six stage bands.
// Depends on bsq_pkg.
module bsq_classify #(
  parameter int ADC_BITS = bsq_pkg::ADC_BITS_DEF
) (
  input  logic [ADC_BITS-1:0] code,
  input  logic [ADC_BITS-1:0] dead_below,
  input  logic [ADC_BITS-1:0] weapon_cut_below,
  input  logic [ADC_BITS-1:0] half_below,
  input  logic [ADC_BITS-1:0] full_below,
  input  logic [ADC_BITS-1:0] overfull_from,
  output bsq_pkg::stage_t raw_class
);

  // Thresholds need not ascend, so the lowest band that matches wins.
  always_comb begin
    priority if (code < dead_below) begin
      raw_class = bsq_pkg::STAGE_DEAD;
    end else if (code < weapon_cut_below) begin
      raw_class = bsq_pkg::STAGE_WEAPON_CUT;
    end else if (code < half_below) begin
      raw_class = bsq_pkg::STAGE_UNDER_HALF;
    end else if (code < full_below) begin
      raw_class = bsq_pkg::STAGE_OVER_HALF;
    end else if (code < overfull_from) begin
      raw_class = bsq_pkg::STAGE_FULL;
    end else begin
      raw_class = bsq_pkg::STAGE_OVERFULL;
    end
  end

endmodule

// ===== src/bsq_dwell.sv =====
// Qualified stage and disagreement timer, updated once per sample word.
// Depends on bsq_pkg.
module bsq_dwell (
  input  logic clk,
  input  logic rst_n,
  input  logic step_en,
  input  bsq_pkg::stage_t raw_class,
  input  bsq_pkg::dwell_cfg_t dwell_cfg,
  output bsq_pkg::result_t result
);

  bsq_pkg::stage_t stage_r, stage_nxt, stage_cur;
  logic [bsq_pkg::MS_BITS-1:0] disagree_r, disagree_nxt, acc;
  logic [bsq_pkg::MS_BITS:0] sum;

  always_comb begin
    // An undefined stage takes the first band at once.
    stage_cur = (stage_r == bsq_pkg::STAGE_UNDEF) ? raw_class : stage_r;
    sum = {1'b0, disagree_r} + (bsq_pkg::MS_BITS + 1)'(dwell_cfg.step_ms);
    if (raw_class != stage_cur) begin
      acc = sum[bsq_pkg::MS_BITS] ? bsq_pkg::MS_MAX : sum[bsq_pkg::MS_BITS-1:0];
    end else begin
      acc = '0;
    end
    if (acc > dwell_cfg.dwell_ms) begin
      stage_nxt = raw_class;
      disagree_nxt = '0;
    end else begin
      stage_nxt = stage_cur;
      disagree_nxt = acc;
    end
    result.stage = stage_nxt;
    result.raw_class = raw_class;
    result.switched = (stage_nxt != stage_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= bsq_pkg::STAGE_UNDEF;
      disagree_r <= '0;
    end else if (step_en) begin
      stage_r <= stage_nxt;
      disagree_r <= disagree_nxt;
    end
  end

endmodule

// ===== src/battery_stage_qualifier.sv =====
// Top level of the battery stage qualifier: sample register, classifier,
// dwell logic, result register and register block. Depends on bsq_pkg, bsq_if.
//
// One ADC sample word enters per clock and one result word leaves per clock
// when the result side keeps ready high. A result word is registered in the
// sample register and then in the result register after its sample is
// accepted, and a stall on the result side can hold it in either. Each
// sample is classified against five threshold codes and the qualified stage
// and disagreement timer are updated in the same cycle that the sample moves
// from the sample register into the result register. While the result
// register is stalled the sample register still takes one more word.
// The user must write thresholds and timer settings through the APB port
// while the block is idle, unchecked by the block itself; pready is always high.
module battery_stage_qualifier #(
  parameter int ADC_BITS = bsq_pkg::ADC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  bsq_in_if.sink in_if,
  bsq_out_if.source out_if,
  input  logic cfg_psel,
  input  logic cfg_penable,
  input  logic cfg_pwrite,
  input  logic [bsq_pkg::CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [bsq_pkg::CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [bsq_pkg::CFG_DATA_BITS-1:0] cfg_prdata,
  output logic cfg_pready
);

  logic [ADC_BITS-1:0] dead_below, weapon_cut_below, half_below;
  logic [ADC_BITS-1:0] full_below, overfull_from;
  bsq_pkg::dwell_cfg_t dwell_cfg;
  bsq_pkg::stage_t raw_class;
  bsq_pkg::result_t result;

  logic smp_valid_r;
  logic [ADC_BITS-1:0] smp_code_r;
  logic res_valid_r;
  bsq_pkg::result_t res_r;
  logic advance;

  assign advance = smp_valid_r & (~res_valid_r | out_if.ready);
  assign in_if.ready = ~smp_valid_r | advance;

  bsq_cfg_regs #(.ADC_BITS(ADC_BITS)) u_cfg (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready),
    .dead_below(dead_below),
    .weapon_cut_below(weapon_cut_below),
    .half_below(half_below),
    .full_below(full_below),
    .overfull_from(overfull_from),
    .dwell_cfg(dwell_cfg)
  );

  bsq_classify #(.ADC_BITS(ADC_BITS)) u_classify (
    .code(smp_code_r),
    .dead_below(dead_below),
    .weapon_cut_below(weapon_cut_below),
    .half_below(half_below),
    .full_below(full_below),
    .overfull_from(overfull_from),
    .raw_class(raw_class)
  );

  bsq_dwell u_dwell (
    .clk(clk),
    .rst_n(rst_n),
    .step_en(advance),
    .raw_class(raw_class),
    .dwell_cfg(dwell_cfg),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      if (in_if.ready) begin
        smp_valid_r <= in_if.valid;
      end
      if (advance) begin
        res_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      smp_code_r <= in_if.adc_code;
    end
    if (advance) begin
      res_r <= result;
    end
  end

  assign out_if.valid = res_valid_r;
  assign out_if.stage = res_r.stage;
  assign out_if.raw_class = res_r.raw_class;
  assign out_if.switched = res_r.switched;

endmodule

// ===== src/bsq_checker.sv =====
// Port-level checks on the result channel of the battery stage qualifier.
// Depends on bsq_pkg; attached to the top level by the bind below.
module bsq_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic [2:0] out_stage,
  input logic [2:0] out_raw_class,
  input logic out_switched
);

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_stage)
      && $stable(out_raw_class) && $stable(out_switched))
    else $error("result word changed while stalled");

  // Every result follows at least one sample, so the stage is defined.
  a_stage_defined: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_stage != bsq_pkg::STAGE_UNDEF)
    else $error("qualified stage undefined on a result word");

  // The band of a sample is never the undefined code nor beyond overfull.
  a_raw_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_raw_class != bsq_pkg::STAGE_UNDEF && out_raw_class != 3'd7)
    else $error("raw band out of range");

  // A switch always lands on the band of the sample that caused it.
  a_switch_to_raw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_switched |-> out_stage == out_raw_class)
    else $error("stage switched to a band other than the sample band");

endmodule

bind battery_stage_qualifier bsq_checker u_bsq_checker (
  .clk(clk),
  .rst_n(rst_n),
  .out_valid(out_if.valid),
  .out_ready(out_if.ready),
  .out_stage(out_if.stage),
  .out_raw_class(out_if.raw_class),
  .out_switched(out_if.switched)
);
